@@ design/bilinear_image_resampler_macros.svh @@
// Assertion macros shared by the resampler checker.
`ifndef BILINEAR_IMAGE_RESAMPLER_MACROS_SVH
`define BILINEAR_IMAGE_RESAMPLER_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define BIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Antecedent now, consequent in the next clock cycle.
`define BIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/bir_pkg.sv @@
// Shared types, constants and helpers of the bilinear resampler.
`default_nettype none
package bir_pkg;

  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_CHANNELS   = 4;

  localparam int XW      = $clog2(MAX_SRC_WIDTH);
  localparam int YW      = $clog2(MAX_SRC_HEIGHT);
  localparam int CHW     = 2;
  localparam int BANK_AW = (XW - 1) + (YW - 1) + CHW;

  localparam int CRD_W  = 12;
  localparam int STEP_W = 24;
  localparam int FRAC_W = 16;
  localparam int POS_W  = STEP_W + CRD_W;
  localparam int INT_W  = POS_W - FRAC_W;

  typedef enum logic [2:0] {
    CFG_SRC_WIDTH     = 3'd0,
    CFG_SRC_HEIGHT    = 3'd1,
    CFG_DST_WIDTH     = 3'd2,
    CFG_DST_HEIGHT    = 3'd3,
    CFG_CHANNEL_COUNT = 3'd4,
    CFG_STEP_X        = 3'd5,
    CFG_STEP_Y        = 3'd6
  } cfg_reg_t;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic       op;
    logic [11:0] col;
    logic [11:0] row;
    logic [1:0]  channel;
    logic [7:0]  sample_in;
  } in_t;

  typedef struct packed {
    logic [7:0] sample_out;
    logic       status;
  } out_t;

  typedef struct packed {
    logic [8:0]  src_width;
    logic [8:0]  src_height;
    logic [11:0] dst_width;
    logic [11:0] dst_height;
    logic [2:0]  channel_count;
    logic [23:0] step_x;
    logic [23:0] step_y;
  } cfg_t;

  // Per-item blend controls that travel with the bank read data.
  typedef struct packed {
    logic              err;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
    logic              xsame;
    logic              ysame;
    logic              x0p;
    logic              y0p;
  } tag_t;

  // Last valid index for a source size clamped to [1, maxv].
  function automatic logic [12:0] last_index(input logic [8:0] dim, input logic [12:0] maxv);
    logic [12:0] e;
    if (dim == 9'd0) begin
      e = 13'd1;
    end else if ({4'b0, dim} > maxv) begin
      e = maxv;
    end else begin
      e = {4'b0, dim};
    end
    return e - 13'd1;
  endfunction

endpackage
`default_nettype wire

@@ design/bir_ram.sv @@
// Simple dual-port RAM with registered read data.
`default_nettype none
module bir_ram #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ design/bir_addr.sv @@
// Input register, source position multiply and bank address generation.
`default_nettype none
module bir_addr (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire logic                             in_valid,
  input  wire bir_pkg::in_t                     in_payload,
  input  wire bir_pkg::cfg_t                    cfg,
  output logic                                  res_valid,
  output bir_pkg::tag_t                         tag,
  output logic [3:0][bir_pkg::BANK_AW-1:0]      rd_addr,
  output logic [3:0]                            wr_en,
  output logic [bir_pkg::BANK_AW-1:0]           wr_addr,
  output logic [7:0]                            wr_data
);

  // stage 0: input register
  logic         v0_r;
  bir_pkg::in_t it0_r;

  // stage 1: products and range checks
  logic                       v1_r, op1_r, err1_r, wok1_r;
  logic [bir_pkg::POS_W-1:0]  px1_r, py1_r;
  logic [bir_pkg::XW-1:0]     lastx1_r;
  logic [bir_pkg::YW-1:0]     lasty1_r;
  bir_pkg::in_t               it1_r;

  // stage 2: clamped coordinates and fractions
  logic                       v2_r, op2_r, wen2_r;
  logic [bir_pkg::XW-1:0]     x02_r;
  logic [bir_pkg::YW-1:0]     y02_r;
  bir_pkg::tag_t              tag2_r;
  bir_pkg::in_t               it2_r;

  logic                       err1_nxt, wok1_nxt;
  logic [bir_pkg::INT_W-1:0]  xu, yu, lx, ly;
  logic [bir_pkg::XW-1:0]     x0_nxt;
  logic [bir_pkg::YW-1:0]     y0_nxt;
  logic [bir_pkg::XW-2:0]     xh;
  logic [bir_pkg::YW-2:0]     yh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_comb begin
    err1_nxt = ({1'b0, it0_r.col} >= {1'b0, cfg.dst_width}) ||
               ({1'b0, it0_r.row} >= {1'b0, cfg.dst_height}) ||
               ({1'b0, it0_r.channel} >= cfg.channel_count) ||
               ({1'b0, it0_r.channel} >= 3'(bir_pkg::MAX_CHANNELS));
    wok1_nxt = ({1'b0, it0_r.col} < 13'(bir_pkg::MAX_SRC_WIDTH)) &&
               ({1'b0, it0_r.row} < 13'(bir_pkg::MAX_SRC_HEIGHT)) &&
               ({1'b0, it0_r.channel} < 3'(bir_pkg::MAX_CHANNELS));
  end

  always_comb begin
    xu = px1_r[bir_pkg::POS_W-1:bir_pkg::FRAC_W];
    yu = py1_r[bir_pkg::POS_W-1:bir_pkg::FRAC_W];
    lx = bir_pkg::INT_W'(lastx1_r);
    ly = bir_pkg::INT_W'(lasty1_r);
    x0_nxt = (xu > lx) ? lastx1_r : xu[bir_pkg::XW-1:0];
    y0_nxt = (yu > ly) ? lasty1_r : yu[bir_pkg::YW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0_r    <= in_payload;
      op1_r    <= it0_r.op;
      err1_r   <= err1_nxt;
      wok1_r   <= wok1_nxt;
      px1_r    <= bir_pkg::POS_W'(cfg.step_x) * bir_pkg::POS_W'(it0_r.col);
      py1_r    <= bir_pkg::POS_W'(cfg.step_y) * bir_pkg::POS_W'(it0_r.row);
      lastx1_r <= bir_pkg::XW'(bir_pkg::last_index(cfg.src_width,
                                                   13'(bir_pkg::MAX_SRC_WIDTH)));
      lasty1_r <= bir_pkg::YW'(bir_pkg::last_index(cfg.src_height,
                                                   13'(bir_pkg::MAX_SRC_HEIGHT)));
      it1_r    <= it0_r;
      op2_r    <= op1_r;
      wen2_r   <= v1_r && (op1_r == bir_pkg::OP_WRITE) && wok1_r;
      x02_r    <= x0_nxt;
      y02_r    <= y0_nxt;
      tag2_r.err   <= err1_r;
      tag2_r.fx    <= px1_r[bir_pkg::FRAC_W-1:0];
      tag2_r.fy    <= py1_r[bir_pkg::FRAC_W-1:0];
      tag2_r.xsame <= (xu >= lx);
      tag2_r.ysame <= (yu >= ly);
      tag2_r.x0p   <= x0_nxt[0];
      tag2_r.y0p   <= y0_nxt[0];
      it2_r    <= it1_r;
    end
  end

  // Bank {yb,xb} holds rows of parity yb and columns of parity xb.
  // The even bank takes the next half index when the base coordinate is odd.
  always_comb begin
    xh = x02_r[bir_pkg::XW-1:1];
    yh = y02_r[bir_pkg::YW-1:1];
    for (int b = 0; b < 4; b++) begin
      rd_addr[b] = {yh + (bir_pkg::YW-1)'(y02_r[0] && (b / 2 == 0)),
                    xh + (bir_pkg::XW-1)'(x02_r[0] && (b % 2 == 0)),
                    it2_r.channel};
      wr_en[b] = en && wen2_r && (it2_r.row[0] == b[1]) && (it2_r.col[0] == b[0]);
    end
  end

  assign wr_addr   = {it2_r.row[bir_pkg::YW-1:1], it2_r.col[bir_pkg::XW-1:1],
                      it2_r.channel};
  assign wr_data   = it2_r.sample_in;
  assign res_valid = v2_r && (op2_r == bir_pkg::OP_REQUEST);
  assign tag       = tag2_r;

endmodule
`default_nettype wire

@@ design/bir_blend.sv @@
// Neighbor selection and two-pass weighted blend.
`default_nettype none
module bir_blend (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             v3,
  input  wire bir_pkg::tag_t    tag3,
  input  wire logic [3:0][7:0]  rdata,
  output logic                  v5,
  output bir_pkg::out_t         res5
);

  logic [7:0]  sa, sb, sc, sd;
  logic [23:0] sa24, sb24, sc24, sd24, fx24, gx24, top_nxt, bot_nxt;
  logic [40:0] sum;
  logic [16:0] gy;

  logic                        v4_r, err4_r, v5_r;
  logic [23:0]                 top4_r, bot4_r;
  logic [bir_pkg::FRAC_W-1:0]  fy4_r;
  bir_pkg::out_t               res5_r, res5_nxt;

  // Clamped neighbors reuse an already selected sample instead of the opposite bank.
  always_comb begin
    sa = rdata[{tag3.y0p, tag3.x0p}];
    sb = tag3.xsame ? sa : rdata[{tag3.y0p, ~tag3.x0p}];
    sc = tag3.ysame ? sa : rdata[{~tag3.y0p, tag3.x0p}];
    if (tag3.xsame && tag3.ysame) begin
      sd = sa;
    end else if (tag3.xsame) begin
      sd = sc;
    end else if (tag3.ysame) begin
      sd = sb;
    end else begin
      sd = rdata[{~tag3.y0p, ~tag3.x0p}];
    end
    sa24 = 24'(sa);
    sb24 = 24'(sb);
    sc24 = 24'(sc);
    sd24 = 24'(sd);
    fx24 = 24'(tag3.fx);
    gx24 = 24'h010000 - fx24;
    top_nxt = sa24 * gx24 + sb24 * fx24;
    bot_nxt = sc24 * gx24 + sd24 * fx24;
  end

  always_comb begin
    gy  = 17'h10000 - {1'b0, fy4_r};
    sum = 41'(top4_r) * 41'(gy) + 41'(bot4_r) * 41'(fy4_r);
    if (err4_r) begin
      res5_nxt.sample_out = 8'd0;
      res5_nxt.status     = 1'b1;
    end else begin
      res5_nxt.sample_out = sum[39:32];
      res5_nxt.status     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top4_r <= top_nxt;
      bot4_r <= bot_nxt;
      fy4_r  <= tag3.fy;
      err4_r <= tag3.err;
      res5_r <= res5_nxt;
    end
  end

  assign v5   = v5_r;
  assign res5 = res5_r;

endmodule
`default_nettype wire

@@ design/bilinear_image_resampler.sv @@
// Top level of the bilinear resampler: config registers, banks, output skid.
//
//   channel | direction | handshake         | payload
//   in_     | input     | in_valid/in_stall | bir_pkg::in_t (write or request)
//   out_    | output    | out_valid/out_stall | bir_pkg::out_t (sample, status)
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One transaction per cycle in while in_stall is low.
// The four neighbors come from four row/column parity banks in the same cycle.
// Reset clears control state only; the source frame holds garbage until written.
// A stalled output fills a one-entry skid, and in_stall follows the skid full flag.
`default_nettype none
module bilinear_image_resampler (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire bir_pkg::in_t   in_payload,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bir_pkg::out_t       out_payload,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [23:0]    cfg_data
);

  bir_pkg::cfg_t cfg_r;

  logic                                en;
  logic                                res_valid2, v3_r, v5;
  bir_pkg::tag_t                       tag2, tag3_r;
  logic [3:0][bir_pkg::BANK_AW-1:0]    rd_addr;
  logic [3:0]                          wr_en;
  logic [bir_pkg::BANK_AW-1:0]         wr_addr;
  logic [7:0]                          wr_data;
  logic [3:0][7:0]                     rdata;
  bir_pkg::out_t                       res5;

  logic          out_valid_r, out_valid_nxt, skid_full_r, skid_full_nxt;
  bir_pkg::out_t out_r, out_nxt, skid_r, skid_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_width     <= 9'd256;
      cfg_r.src_height    <= 9'd256;
      cfg_r.dst_width     <= 12'd256;
      cfg_r.dst_height    <= 12'd256;
      cfg_r.channel_count <= 3'd1;
      cfg_r.step_x        <= 24'd0;
      cfg_r.step_y        <= 24'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bir_pkg::CFG_SRC_WIDTH:     cfg_r.src_width     <= cfg_data[8:0];
        bir_pkg::CFG_SRC_HEIGHT:    cfg_r.src_height    <= cfg_data[8:0];
        bir_pkg::CFG_DST_WIDTH:     cfg_r.dst_width     <= cfg_data[11:0];
        bir_pkg::CFG_DST_HEIGHT:    cfg_r.dst_height    <= cfg_data[11:0];
        bir_pkg::CFG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_data[2:0];
        bir_pkg::CFG_STEP_X:        cfg_r.step_x        <= cfg_data;
        bir_pkg::CFG_STEP_Y:        cfg_r.step_y        <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together unless the skid holds a result.
  assign en       = !skid_full_r;
  assign in_stall = skid_full_r;

  bir_addr u_addr (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_payload (in_payload),
    .cfg        (cfg_r),
    .res_valid  (res_valid2),
    .tag        (tag2),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bir_ram #(
      .AW (bir_pkg::BANK_AW),
      .DW (8)
    ) u_bank (
      .clk   (clk),
      .we    (wr_en[b]),
      .waddr (wr_addr),
      .wdata (wr_data),
      .re    (en),
      .raddr (rd_addr[b]),
      .rdata (rdata[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= res_valid2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag3_r <= tag2;
    end
  end

  bir_blend u_blend (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v3    (v3_r),
    .tag3  (tag3_r),
    .rdata (rdata),
    .v5    (v5),
    .res5  (res5)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    skid_full_nxt = skid_full_r;
    out_nxt       = out_r;
    skid_nxt      = skid_r;
    if (skid_full_r) begin
      // drain the skid once the output moves
      if (!out_stall) begin
        out_nxt       = skid_r;
        skid_full_nxt = 1'b0;
      end
    end else if (out_valid_r && out_stall) begin
      // hold the output, park a new result in the skid
      if (v5) begin
        skid_nxt      = res5;
        skid_full_nxt = 1'b1;
      end
    end else begin
      out_valid_nxt = v5;
      out_nxt       = res5;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      skid_full_r <= skid_full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_payload = out_r;

endmodule
`default_nettype wire

@@ design/bir_checker.sv @@
// Port-level checker for the bilinear resampler, bound to the top level.
`default_nettype none
`include "bilinear_image_resampler_macros.svh"
module bir_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire bir_pkg::out_t out_payload,
  input wire logic          cfg_valid,
  input wire logic          cfg_ready
);

  `BIR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_payload), "stalled result changed")
  `BIR_ASSERT(a_err_zero, (out_valid && out_payload.status) |-> (out_payload.sample_out == 8'd0), "error result carries a sample")
  `BIR_ASSERT(a_stall_cause, in_stall |-> $past(out_stall), "input stalled without output back-pressure")
  `BIR_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "config write refused")

endmodule

bind bilinear_image_resampler bir_checker u_bir_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_payload (out_payload),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready)
);
`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking bench for the bilinear resampler: random stimulus, predictor, scoreboard.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam logic      STATUS_OK   = 1'b0;
  localparam logic      STATUS_ERR  = 1'b1;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int        DRAIN_CYC   = 12;
  localparam int        HOLD_CYC    = 200;
  localparam int        IDLE_LIMIT  = 3000;

  class resample_scoreboard;
    byte unsigned frame [bir_pkg::MAX_SRC_WIDTH*bir_pkg::MAX_SRC_HEIGHT*bir_pkg::MAX_CHANNELS];
    logic [8:0]  src_w, src_h;
    logic [11:0] dst_w, dst_h;
    logic [2:0]  chans;
    logic [23:0] stx, sty;
    bir_pkg::out_t pending_samples [$];

    function new();
      foreach (frame[i]) frame[i] = 0;
      src_w = 9'd256; src_h = 9'd256; dst_w = 12'd256; dst_h = 12'd256;
      chans = 3'd1; stx = '0; sty = '0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [23:0] d);
      case (idx)
        bir_pkg::CFG_SRC_WIDTH:     src_w = d[8:0];
        bir_pkg::CFG_SRC_HEIGHT:    src_h = d[8:0];
        bir_pkg::CFG_DST_WIDTH:     dst_w = d[11:0];
        bir_pkg::CFG_DST_HEIGHT:    dst_h = d[11:0];
        bir_pkg::CFG_CHANNEL_COUNT: chans = d[2:0];
        bir_pkg::CFG_STEP_X:        stx = d;
        bir_pkg::CFG_STEP_Y:        sty = d;
        default: ;
      endcase
    endfunction

    function int unsigned addr(int unsigned c, int unsigned r, int unsigned ch);
      return (r * bir_pkg::MAX_SRC_WIDTH + c) * bir_pkg::MAX_CHANNELS + ch;
    endfunction

    function int unsigned last_of(logic [8:0] dim, int unsigned maxv);
      if (dim == 0) return 0;
      if (dim > maxv) return maxv - 1;
      return dim - 1;
    endfunction

    function int unsigned clip(logic [63:0] v, int unsigned last);
      return (v > last) ? last : int'(v);
    endfunction

    function void note_input(bir_pkg::in_t it);
      bir_pkg::out_t r;
      logic [63:0] px, py, fx, fy, gx, gy, sum;
      int unsigned lx, ly, x0, x1, y0, y1;
      if (it.op == bir_pkg::OP_WRITE) begin
        if (it.col < bir_pkg::MAX_SRC_WIDTH && it.row < bir_pkg::MAX_SRC_HEIGHT &&
            it.channel < bir_pkg::MAX_CHANNELS)
          frame[addr(it.col, it.row, it.channel)] = it.sample_in;
        return;
      end
      if (it.col >= dst_w || it.row >= dst_h || it.channel >= chans ||
          it.channel >= bir_pkg::MAX_CHANNELS) begin
        r.sample_out = '0;
        r.status = STATUS_ERR;
      end else begin
        lx = last_of(src_w, bir_pkg::MAX_SRC_WIDTH);
        ly = last_of(src_h, bir_pkg::MAX_SRC_HEIGHT);
        px = 64'(stx) * 64'(it.col);
        py = 64'(sty) * 64'(it.row);
        fx = {48'd0, px[15:0]};
        fy = {48'd0, py[15:0]};
        gx = 64'd65536 - fx;
        gy = 64'd65536 - fy;
        x0 = clip(px >> 16, lx);
        x1 = clip((px >> 16) + 1, lx);
        y0 = clip(py >> 16, ly);
        y1 = clip((py >> 16) + 1, ly);
        sum = 64'(frame[addr(x0, y0, it.channel)]) * gx * gy
            + 64'(frame[addr(x1, y0, it.channel)]) * fx * gy
            + 64'(frame[addr(x0, y1, it.channel)]) * gx * fy
            + 64'(frame[addr(x1, y1, it.channel)]) * fx * fy;
        r.sample_out = sum[39:32];
        r.status = STATUS_OK;
      end
      pending_samples.push_back(r);
    endfunction

    // Returns an empty string when the result matches.
    function string check_result(bir_pkg::out_t got);
      bir_pkg::out_t exp_r;
      if (pending_samples.size() == 0) return "result with nothing expected";
      exp_r = pending_samples.pop_front();
      if (got.status !== exp_r.status)
        return $sformatf("status got %0d want %0d", got.status, exp_r.status);
      if (got.sample_out !== exp_r.sample_out)
        return $sformatf("sample got %0d want %0d", got.sample_out, exp_r.sample_out);
      return "";
    endfunction

    function int outstanding();
      return pending_samples.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  bir_pkg::in_t  in_payload = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  bir_pkg::out_t out_payload;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [2:0]    cfg_index = '0;
  logic [23:0]   cfg_data = '0;

  resample_scoreboard sb = new();
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int hold_asks = 0, hold_served = 0, hold_left = 0;
  int rx_mode = 0, rx_phase = 0;

  bilinear_image_resampler dut (.*);

  always #6 clk = ~clk;

  task automatic report(string msg);
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Monitors: sample every transaction at the rising edge.
  always @(posedge clk) begin
    string m;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_input(in_payload);
      if (out_valid && !out_stall) begin
        m = sb.check_result(out_payload);
        if (m != "") report(m);
      end
      if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // Receiver: long hold on request, otherwise a stall pattern that is re-picked at random from time to time.
  always @(negedge clk) begin
    if (hold_asks != hold_served) begin
      hold_served = hold_asks;
      hold_left = HOLD_CYC;
    end
    rx_phase++;
    if (rx_phase % 64 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= rx_phase[0];
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [23:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push(bir_pkg::in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_payload <= it;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic bir_pkg::in_t item(logic op, int c, int r, int ch, int s);
    bir_pkg::in_t it;
    it.op = op;
    it.col = c[11:0];
    it.row = r[11:0];
    it.channel = ch[1:0];
    it.sample_in = s[7:0];
    return it;
  endfunction

  // Drop valid, let every result arrive, then let the pipeline empty.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // step_mode: 0 nominal, 1 oversized (neighbor clamping), 2 maximum.
  task automatic run_phase(int sw, int sh, int dw, int dh, int cc, int step_mode,
                           int n_rand, bit directed);
    int ew, eh, ec, sx, sy, k, pick;
    ew = (sw == 0) ? 1 : (sw > bir_pkg::MAX_SRC_WIDTH) ? bir_pkg::MAX_SRC_WIDTH : sw;
    eh = (sh == 0) ? 1 : (sh > bir_pkg::MAX_SRC_HEIGHT) ? bir_pkg::MAX_SRC_HEIGHT : sh;
    ec = (cc > bir_pkg::MAX_CHANNELS) ? bir_pkg::MAX_CHANNELS : cc;
    case (step_mode)
      0: begin
        sx = ((ew - 1) * 65536) / dw;
        sy = ((eh - 1) * 65536) / dh;
      end
      1: begin
        sx = $urandom_range(0, 24'h0FFFFF);
        sy = $urandom_range(0, 24'h0FFFFF);
      end
      default: begin
        sx = 24'hFFFFFF;
        sy = 24'hFFFFFF;
      end
    endcase
    write_cfg(bir_pkg::CFG_SRC_WIDTH, 24'(sw));
    write_cfg(bir_pkg::CFG_SRC_HEIGHT, 24'(sh));
    write_cfg(bir_pkg::CFG_DST_WIDTH, 24'(dw));
    write_cfg(bir_pkg::CFG_DST_HEIGHT, 24'(dh));
    write_cfg(bir_pkg::CFG_CHANNEL_COUNT, 24'(cc));
    write_cfg(bir_pkg::CFG_STEP_X, 24'(sx));
    write_cfg(bir_pkg::CFG_STEP_Y, 24'(sy));
    write_cfg(CFG_UNUSED, 24'($urandom()));

    // Fill the whole effective source so no request reads an unwritten entry.
    for (int r = 0; r < eh; r++)
      for (int c = 0; c < ew; c++)
        for (int ch = 0; ch < ec; ch++)
          push(item(bir_pkg::OP_WRITE, c, r, ch, $urandom_range(0, 255)));

    if (directed) begin
      push(item(bir_pkg::OP_WRITE, 0, 0, 0, 0));
      push(item(bir_pkg::OP_WRITE, ew - 1, eh - 1, ec - 1, 255));
      push(item(bir_pkg::OP_WRITE, 4095, 4095, 3, 8'hAA));
      push(item(bir_pkg::OP_WRITE, bir_pkg::MAX_SRC_WIDTH, 0, 0, 8'h55));
      push(item(bir_pkg::OP_REQUEST, 0, 0, 0, 255));
      push(item(bir_pkg::OP_REQUEST, dw - 1, dh - 1, ec - 1, 0));
      push(item(bir_pkg::OP_REQUEST, dw - 1, 0, 0, 0));
      push(item(bir_pkg::OP_REQUEST, 0, dh - 1, 0, 0));
      push(item(bir_pkg::OP_REQUEST, dw, 0, 0, 0));
      push(item(bir_pkg::OP_REQUEST, 0, dh, 0, 0));
      push(item(bir_pkg::OP_REQUEST, 0, 0, 3, 0));
      push(item(bir_pkg::OP_REQUEST, 4095, 4095, 3, 255));
      push(item(bir_pkg::OP_REQUEST, 0, 0, ec, 0));
    end

    for (k = 0; k < n_rand; k++) begin
      if (directed && k == 20) hold_asks++;
      if (directed && k == 80) drain();
      pick = $urandom_range(0, 99);
      if (pick < 60)
        push(item(bir_pkg::OP_REQUEST,
                  ($urandom_range(0, 9) == 0) ? dw - 1 : $urandom_range(0, dw - 1),
                  ($urandom_range(0, 9) == 0) ? dh - 1 : $urandom_range(0, dh - 1),
                  $urandom_range(0, ec - 1), $urandom_range(0, 255)));
      else if (pick < 70)
        push(item(bir_pkg::OP_REQUEST, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 3), $urandom_range(0, 255)));
      else if (pick < 90)
        push(item(bir_pkg::OP_WRITE, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1),
                  $urandom_range(0, ec - 1), $urandom_range(0, 255)));
      else
        push(item(bir_pkg::OP_WRITE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom_range(0, 3), $urandom_range(0, 255)));
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    drain();
    run_phase(4, 4, 7, 5, 4, 0, 200, 1'b1);
    run_phase(2, 2, 1, 1, 1, 0, 60, 1'b0);
    run_phase(0, 3, 16, 16, 2, 0, 100, 1'b0);
    run_phase(300, 0, 4095, 4095, 1, 1, 100, 1'b0);
    run_phase(3, 3, 33, 3, 5, 2, 60, 1'b0);
    for (int p = 0; p < 2; p++)
      run_phase($urandom_range(2, 5), $urandom_range(2, 5), $urandom_range(1, 64),
                $urandom_range(1, 64), $urandom_range(1, 4), $urandom_range(0, 1),
                40, 1'b0);
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
